@@ rtl/psob_pkg.sv @@
// shared types and constants for the premultiplied source-over blend core
`timescale 1ns / 1ps

package psob_pkg;

    localparam int unsigned NUM_CH = 4;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned PIX_W  = NUM_CH * CH_W;
    localparam int unsigned OP_W   = 17;

    localparam logic [OP_W-1:0]  OPACITY_ONE = 17'h10000;
    localparam logic [CH_W-1:0]  CH_MAX      = 8'hff;
    localparam logic [23:0]      ROUND_Q16   = 24'd32768;
    localparam logic [15:0]      ROUND_255   = 16'd127;
    // floor(x / 255) == (x * 32897) >> 23 for every x below 66060
    localparam logic [15:0]      RECIP_255   = 16'd32897;
    localparam int unsigned      RECIP_SHIFT = 23;

    typedef enum logic [1:0] {
        SEL_DST,
        SEL_SRC,
        SEL_BLEND
    } blend_sel_t;

    typedef struct packed {
        logic        zero;
        logic        full;
        logic [15:0] frac;
    } opacity_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] src;
        logic [PIX_W-1:0] dst;
        logic             bypass;
    } pix_pair_t;

endpackage

@@ rtl/premultiplied_source_over_blend_core.sv @@
// top level of the premultiplied source-over blend core
`timescale 1ns / 1ps

//  channel   signals                                  width    role
//  cfg       cfg_wr_en, cfg_wr_data                   1, 17    layer opacity write
//  in        in_valid, in_ready, src_pixel, dst_pixel 32, 32   pixel pair transaction
//  out       out_valid, out_ready, out_pixel          32       composited pixel transaction
//
//  one transaction per clock sustained while the output is not stalled; a pixel taken
//  in passes through the scale stages and then the over stages to the output register
//  there are five pipeline stages: two for opacity scaling, three for over
//  reset clears all stage valid bits and loads full opacity
//  each stage holds while the one after it is full and stalled; bubbles collapse,
//  so input is still taken while a finished pixel waits at the output

module premultiplied_source_over_blend_core
    import psob_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [OP_W-1:0]  cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] src_pixel,
    input  logic [PIX_W-1:0] dst_pixel,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel
);

    // layer opacity, Q1.16
    logic [OP_W-1:0] opacity_reg;
    opacity_ctl_t    op_ctl;

    // scale-to-over handoff
    logic            mid_valid;
    logic            mid_ready;
    pix_pair_t       mid_pair;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opacity_reg <= OPACITY_ONE;
        end
        else if (cfg_wr_en)
        begin
            opacity_reg <= cfg_wr_data;
        end
    end

    // values above one saturate to full opacity
    always_comb
    begin
        op_ctl.zero = (opacity_reg == '0);
        op_ctl.full = (opacity_reg >= OPACITY_ONE);
        op_ctl.frac = opacity_reg[15:0];
    end

    psob_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_ctl    (op_ctl),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .src       (src_pixel),
        .dst       (dst_pixel),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_pair  (mid_pair)
    );

    psob_over u_over (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_pair   (mid_pair),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_pixel (out_pixel)
    );

`ifndef SYNTHESIS
    a_opacity_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(op_ctl.zero && op_ctl.full))
        else $error("opacity both zero and full");

    a_cfg_load: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (opacity_reg == $past(cfg_wr_data)))
        else $error("opacity write not taken");

    a_handoff_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (mid_valid && !mid_ready) |=> (mid_valid && $stable(mid_pair)))
        else $error("internal handoff dropped a stalled transaction");
`endif

endmodule

@@ rtl/psob_scale.sv @@
// opacity scaling of the source pixel, two register stages
`timescale 1ns / 1ps

module psob_scale
    import psob_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  opacity_ctl_t     op_ctl,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PIX_W-1:0] src,
    input  logic [PIX_W-1:0] dst,
    output logic             out_valid,
    input  logic             out_ready,
    output pix_pair_t        out_pair
);

    logic             s1_valid_reg;
    logic [23:0]      s1_prod_reg [NUM_CH];
    logic [23:0]      s1_prod_next [NUM_CH];
    logic [PIX_W-1:0] s1_src_reg;
    logic [PIX_W-1:0] s1_dst_reg;
    logic             s1_zero_reg;
    logic             s1_full_reg;

    logic             s2_valid_reg;
    pix_pair_t        s2_pair_reg;
    pix_pair_t        s2_pair_next;

    logic             en1;
    logic             en2;

    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    // stage 1: channel times opacity fraction
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            s1_prod_next[i] = 24'(src[i*CH_W +: CH_W]) * 24'(op_ctl.frac);
        end
    end

    // stage 2: round half up, keep the integer part; full opacity passes the source unscaled
    always_comb
    begin
        s2_pair_next.dst    = s1_dst_reg;
        s2_pair_next.bypass = s1_zero_reg;
        s2_pair_next.src    = s1_src_reg;
        if (!s1_full_reg)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                s2_pair_next.src[i*CH_W +: CH_W] = 8'((s1_prod_reg[i] + ROUND_Q16) >> 16);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_src_reg  <= src;
            s1_dst_reg  <= dst;
            s1_zero_reg <= op_ctl.zero;
            s1_full_reg <= op_ctl.full;
        end
        if (en2 && s1_valid_reg)
        begin
            s2_pair_reg <= s2_pair_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_pair  = s2_pair_reg;

`ifndef SYNTHESIS
    a_s1_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && en2) |=> s2_valid_reg)
        else $error("stage 1 transaction lost on advance");

    a_full_unscaled: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && en2 && s1_full_reg) |=> (s2_pair_reg.src == $past(s1_src_reg)))
        else $error("full opacity altered the source");

    a_zero_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && en2 && s1_zero_reg) |=> s2_pair_reg.bypass)
        else $error("zero opacity did not mark bypass");
`endif

endmodule

@@ rtl/psob_over.sv @@
// source-over compositing with divide by 255, three register stages
`timescale 1ns / 1ps

module psob_over
    import psob_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pix_pair_t        in_pair,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pixel
);

    logic             s3_valid_reg;
    logic [15:0]      s3_x_reg [NUM_CH];
    logic [15:0]      s3_x_next [NUM_CH];
    logic [PIX_W-1:0] s3_src_reg;
    logic [PIX_W-1:0] s3_dst_reg;
    blend_sel_t       s3_sel_reg;
    blend_sel_t       s3_sel_next;

    logic             s4_valid_reg;
    logic [CH_W-1:0]  s4_q_reg [NUM_CH];
    logic [CH_W-1:0]  s4_q_next [NUM_CH];
    logic [31:0]      s4_prod [NUM_CH];
    logic [PIX_W-1:0] s4_src_reg;
    logic [PIX_W-1:0] s4_dst_reg;
    blend_sel_t       s4_sel_reg;

    logic             s5_valid_reg;
    logic [PIX_W-1:0] s5_pix_reg;
    logic [PIX_W-1:0] s5_pix_next;
    logic [CH_W:0]    s5_sum [NUM_CH];

    logic [CH_W-1:0]  alpha;
    logic [CH_W-1:0]  inv_alpha;

    logic             en3;
    logic             en4;
    logic             en5;

    assign en5      = !s5_valid_reg || out_ready;
    assign en4      = !s4_valid_reg || en5;
    assign en3      = !s3_valid_reg || en4;
    assign in_ready = en3;

    assign alpha     = in_pair.src[PIX_W-1 -: CH_W];
    assign inv_alpha = CH_MAX - alpha;

    // stage 3: pick the path, destination times (255 - alpha) plus half
    always_comb
    begin
        priority if (in_pair.bypass || alpha == '0)
        begin
            s3_sel_next = SEL_DST;
        end
        else if (alpha == CH_MAX)
        begin
            s3_sel_next = SEL_SRC;
        end
        else
        begin
            s3_sel_next = SEL_BLEND;
        end
        for (int i = 0; i < NUM_CH; i++)
        begin
            s3_x_next[i] = 16'(in_pair.dst[i*CH_W +: CH_W]) * 16'(inv_alpha) + ROUND_255;
        end
    end

    // stage 4: divide by 255 through the reciprocal
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            s4_prod[i]   = 32'(s3_x_reg[i]) * 32'(RECIP_255);
            s4_q_next[i] = 8'(s4_prod[i] >> RECIP_SHIFT);
        end
    end

    // stage 5: add, clamp, select
    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            s5_sum[i] = {1'b0, s4_src_reg[i*CH_W +: CH_W]} + {1'b0, s4_q_reg[i]};
        end
        unique case (s4_sel_reg)
            SEL_DST:
            begin
                s5_pix_next = s4_dst_reg;
            end
            SEL_SRC:
            begin
                s5_pix_next = s4_src_reg;
            end
            SEL_BLEND:
            begin
                for (int i = 0; i < NUM_CH; i++)
                begin
                    s5_pix_next[i*CH_W +: CH_W] = s5_sum[i][CH_W] ? CH_MAX : s5_sum[i][CH_W-1:0];
                end
            end
            default:
            begin
                s5_pix_next = s4_dst_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (en3)
            begin
                s3_valid_reg <= in_valid;
            end
            if (en4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (en5)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && in_valid)
        begin
            s3_x_reg   <= s3_x_next;
            s3_src_reg <= in_pair.src;
            s3_dst_reg <= in_pair.dst;
            s3_sel_reg <= s3_sel_next;
        end
        if (en4 && s3_valid_reg)
        begin
            s4_q_reg   <= s4_q_next;
            s4_src_reg <= s3_src_reg;
            s4_dst_reg <= s3_dst_reg;
            s4_sel_reg <= s3_sel_reg;
        end
        if (en5 && s4_valid_reg)
        begin
            s5_pix_reg <= s5_pix_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_pixel = s5_pix_reg;

`ifndef SYNTHESIS
    a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && s4_sel_reg == SEL_BLEND) |->
        (s4_q_reg[0] < CH_MAX && s4_q_reg[1] < CH_MAX &&
         s4_q_reg[2] < CH_MAX && s4_q_reg[3] < CH_MAX))
        else $error("quotient out of range for partial alpha");

    a_src_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && s3_sel_reg == SEL_SRC) |-> (s3_src_reg[PIX_W-1 -: CH_W] == CH_MAX))
        else $error("source path chosen without opaque alpha");

    a_s4_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s4_valid_reg && en5) |=> s5_valid_reg)
        else $error("stage 4 transaction lost on advance");
`endif

endmodule
